>>> hdl/chs_pkg.sv
// Constants shared by the cabinet header scanner.
package chs_pkg;

    // Width of the running stream byte position (16 to 64).
    localparam int POSITION_WIDTH = 32;

    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 32;
    localparam int PHASE_W  = 5;
    localparam int OUT_W    = 3 * FIELD_W;

    // Signature bytes "MSCF".
    localparam logic [BYTE_W-1:0] SIG_M = 8'h4D;
    localparam logic [BYTE_W-1:0] SIG_S = 8'h53;
    localparam logic [BYTE_W-1:0] SIG_C = 8'h43;
    localparam logic [BYTE_W-1:0] SIG_F = 8'h46;

    localparam logic [FIELD_W-1:0] HEADER_BYTES = 32'd20;

    // Scan phase codes: the index of the next header byte.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
    localparam logic [PHASE_W-1:0] PH_SIG_S = 5'd1;
    localparam logic [PHASE_W-1:0] PH_SIG_C = 5'd2;
    localparam logic [PHASE_W-1:0] PH_SIG_F = 5'd3;
    localparam logic [PHASE_W-1:0] PH_LEN0  = 5'd8;
    localparam logic [PHASE_W-1:0] PH_LEN3  = 5'd11;
    localparam logic [PHASE_W-1:0] PH_OFS0  = 5'd16;
    localparam logic [PHASE_W-1:0] PH_LAST  = 5'd19;

endpackage

>>> hdl/cabinet_header_scanner.sv
// Cabinet header scanner: finds "MSCF" headers in a byte stream.
//
// One byte enters per transaction on the s_ side and the block takes a byte in
// every cycle while s_tready is high, with the whole per-byte update (phase
// step, field capture, the 32-bit compares and subtract) done in a single pass
// into the state and result registers. A result waits in the m_ output register;
// s_tready is high while that register is empty or being taken, so the stream
// stalls only when a result is held off by m_tready. After the signature, header
// bytes 4-7 and 12-15 are ignored, bytes 8-11 give the little-endian cabinet
// length and bytes 16-19 the files offset. On the 20th byte, if the files offset
// is below the length, one result goes out with the position of the 'M' (low 32
// bits), the length and the offset, and the remaining length minus 20 bytes of
// that cabinet are then passed over without scanning. A wrong signature byte
// returns to searching without rechecking that byte as an 'M'. The byte position
// counter saturates at its maximum.
module cabinet_header_scanner
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [chs_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [chs_pkg::OUT_W-1:0]     m_tdata    // [31:0] header_position,
                                                     // [63:32] cabinet_length,
                                                     // [95:64] file_table_offset
);

    localparam logic [chs_pkg::POSITION_WIDTH-1:0] POS_MAX  = '1;
    localparam logic [chs_pkg::POSITION_WIDTH-1:0] POS_BACK =
        chs_pkg::POSITION_WIDTH'(chs_pkg::HEADER_BYTES - 32'd1);

    logic [chs_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic [chs_pkg::FIELD_W-1:0]        length_reg, length_next;
    logic [chs_pkg::FIELD_W-1:0]        offset_reg, offset_next;
    logic [chs_pkg::POSITION_WIDTH-1:0] position_reg, position_next;
    logic [chs_pkg::FIELD_W-1:0]        skip_reg, skip_next;
    logic                               m_valid_reg, m_valid_next;
    logic [chs_pkg::OUT_W-1:0]          m_data_reg, m_data_next;

    logic                               accept;
    logic                               emit;
    logic [chs_pkg::FIELD_W-1:0]        offset_full;
    logic [chs_pkg::POSITION_WIDTH-1:0] start_pos;
    logic [63:0]                        start_wide;
    logic [1:0]                         lane;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Final offset as it stands once the last header byte is in.
    assign offset_full = {s_tdata, offset_reg[23:0]};
    assign start_pos   = (position_reg >= POS_BACK) ? position_reg - POS_BACK : '0;
    assign start_wide  = 64'(start_pos);
    assign lane        = phase_reg[1:0];

    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        offset_next   = offset_reg;
        skip_next     = skip_reg;
        position_next = position_reg;
        emit          = 1'b0;

        if (accept)
        begin
            if (position_reg != POS_MAX)
            begin
                position_next = position_reg + 1'b1;
            end

            if (skip_reg != '0)
            begin
                // passing over the body of an accepted cabinet
                skip_next = skip_reg - 1'b1;
            end
            else
            begin
                priority if (phase_reg == chs_pkg::PH_IDLE)
                begin
                    if (s_tdata == chs_pkg::SIG_M)
                    begin
                        phase_next = chs_pkg::PH_SIG_S;
                    end
                end
                else if (phase_reg == chs_pkg::PH_SIG_S)
                begin
                    phase_next = (s_tdata == chs_pkg::SIG_S) ? chs_pkg::PH_SIG_C
                                                             : chs_pkg::PH_IDLE;
                end
                else if (phase_reg == chs_pkg::PH_SIG_C)
                begin
                    phase_next = (s_tdata == chs_pkg::SIG_C) ? chs_pkg::PH_SIG_F
                                                             : chs_pkg::PH_IDLE;
                end
                else if (phase_reg == chs_pkg::PH_SIG_F)
                begin
                    phase_next = (s_tdata == chs_pkg::SIG_F) ? phase_reg + 1'b1
                                                             : chs_pkg::PH_IDLE;
                end
                else if (phase_reg == chs_pkg::PH_LAST)
                begin
                    offset_next = offset_full;
                    if (offset_full < length_reg)
                    begin
                        emit      = 1'b1;
                        skip_next = (length_reg > chs_pkg::HEADER_BYTES)
                                  ? length_reg - chs_pkg::HEADER_BYTES : '0;
                    end
                    phase_next = chs_pkg::PH_IDLE;
                end
                else if (phase_reg > chs_pkg::PH_LAST)
                begin
                    // unreachable codes fall back to searching
                    phase_next = chs_pkg::PH_IDLE;
                end
                else
                begin
                    // header bytes 4..18; every lane is rewritten before use
                    if (phase_reg >= chs_pkg::PH_LEN0 && phase_reg <= chs_pkg::PH_LEN3)
                    begin
                        length_next[lane*8 +: 8] = s_tdata;
                    end
                    else if (phase_reg >= chs_pkg::PH_OFS0)
                    begin
                        offset_next[lane*8 +: 8] = s_tdata;
                    end
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (accept)
        begin
            m_valid_next = emit;
            if (emit)
            begin
                m_data_next = {offset_full, length_reg, start_wide[31:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= chs_pkg::PH_IDLE;
            position_reg <= '0;
            skip_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            skip_reg     <= skip_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        length_reg <= length_next;
        offset_reg <= offset_next;
        m_data_reg <= m_data_next;
    end

endmodule
